>>> src/lsc_pkg.sv
package lsc_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIV_BITS_PER_STAGE = 2;
	localparam int DIV_STAGES = COORD_BITS / DIV_BITS_PER_STAGE;
	localparam int LANES = 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0] snum_t;
	typedef logic [COORD_BITS-1:0] mag_t;
	typedef logic [2*COORD_BITS-1:0] prod_t;
	typedef logic signed [2*COORD_BITS+1:0] sprod_t;
	typedef logic signed [COORD_BITS+1:0] wide_t;
	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t REG_LEFT = 2'd0;
	localparam cfg_idx_t REG_RIGHT = 2'd1;
	localparam cfg_idx_t REG_BOTTOM = 2'd2;
	localparam cfg_idx_t REG_TOP = 2'd3;

	localparam coord_t WIN_LEFT_RST = coord_t'(-100);
	localparam coord_t WIN_RIGHT_RST = coord_t'(100);
	localparam coord_t WIN_BOTTOM_RST = coord_t'(-100);
	localparam coord_t WIN_TOP_RST = coord_t'(100);

	typedef struct packed {
		prod_t num;
		mag_t den;
		coord_t base;
		logic neg;
	} div_in_t;

	typedef struct packed {
		mag_t quo;
		logic rem_nz;
		coord_t base;
		logic neg;
	} div_out_t;

endpackage

>>> src/lsc_divider.sv
module lsc_divider (
	input logic clk,
	input logic adv,
	input lsc_pkg::div_in_t din,
	output lsc_pkg::div_out_t dout
);

	typedef struct packed {
		lsc_pkg::mag_t rem;
		lsc_pkg::mag_t low;
		lsc_pkg::mag_t quo;
		lsc_pkg::mag_t den;
		lsc_pkg::coord_t base;
		logic neg;
	} dstage_t;

	function automatic dstage_t div_steps(dstage_t s_in);
		dstage_t s;
		logic [lsc_pkg::COORD_BITS:0] trial;
		logic fits;
		s = s_in;
		for (int i = 0; i < lsc_pkg::DIV_BITS_PER_STAGE; i++) begin
			trial = {s.rem, s.low[lsc_pkg::COORD_BITS-1]};
			fits = trial >= {1'b0, s.den};
			if (fits) begin
				trial = trial - {1'b0, s.den};
			end
			s.rem = trial[lsc_pkg::COORD_BITS-1:0];
			s.low = {s.low[lsc_pkg::COORD_BITS-2:0], 1'b0};
			s.quo = {s.quo[lsc_pkg::COORD_BITS-2:0], fits};
		end
		return s;
	endfunction

	dstage_t init_c;
	dstage_t stage_s [lsc_pkg::DIV_STAGES];
	dstage_t next_c [lsc_pkg::DIV_STAGES];

	// The quotient fits in COORD_BITS because the parameter never exceeds one.
	always_comb begin
		init_c.rem = din.num[2*lsc_pkg::COORD_BITS-1:lsc_pkg::COORD_BITS];
		init_c.low = din.num[lsc_pkg::COORD_BITS-1:0];
		init_c.quo = '0;
		init_c.den = din.den;
		init_c.base = din.base;
		init_c.neg = din.neg;
	end

	for (genvar g = 0; g < lsc_pkg::DIV_STAGES; g++) begin : g_stage
		if (g == 0) begin : g_first
			assign next_c[g] = div_steps(init_c);
		end else begin : g_rest
			assign next_c[g] = div_steps(stage_s[g-1]);
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stage_s[g] <= next_c[g];
			end
		end
	end

	assign dout.quo = stage_s[lsc_pkg::DIV_STAGES-1].quo;
	assign dout.rem_nz = |stage_s[lsc_pkg::DIV_STAGES-1].rem;
	assign dout.base = stage_s[lsc_pkg::DIV_STAGES-1].base;
	assign dout.neg = stage_s[lsc_pkg::DIV_STAGES-1].neg;

endmodule

>>> src/line_segment_clipper.sv
// Liang-Barsky line clipper against a configurable rectangle.
// Input channel: in_valid/in_stall carries one segment word (start_x, start_y,
// end_x, end_y). Output channel: out_valid/out_stall carries one result word
// (visible and the clipped endpoints) for every segment, in order.
// A word moves at a rising edge where valid is high and stall is low.
// The result of a segment passes through six stages of edge parameter
// arithmetic and cross-multiplied compares, then a restoring divider that
// retires two quotient bits per stage, then the output register.
// One segment is accepted every cycle while the output is not stalled.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
// The window registers are written through cfg_write, cfg_index and cfg_data
// and should only change while no segment is in flight.
// Reset empties the pipeline and loads the window with -100..100 on both axes.
// Rejected segments return visible low and all coordinates zero.
module line_segment_clipper (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lsc_pkg::coord_t start_x,
	input lsc_pkg::coord_t start_y,
	input lsc_pkg::coord_t end_x,
	input lsc_pkg::coord_t end_y,
	output logic out_valid,
	input logic out_stall,
	output logic visible,
	output lsc_pkg::coord_t clip_start_x,
	output lsc_pkg::coord_t clip_start_y,
	output lsc_pkg::coord_t clip_end_x,
	output lsc_pkg::coord_t clip_end_y,
	input logic cfg_write,
	input lsc_pkg::cfg_idx_t cfg_index,
	input lsc_pkg::coord_t cfg_data
);

	localparam int C = lsc_pkg::COORD_BITS;
	localparam int LAST = lsc_pkg::DIV_STAGES - 1;

	typedef struct packed {
		lsc_pkg::coord_t x0;
		lsc_pkg::coord_t y0;
		logic xneg;
		logic yneg;
		lsc_pkg::mag_t adx;
		lsc_pkg::mag_t ady;
		logic rej;
	} geo_t;

	typedef struct packed {
		lsc_pkg::mag_t den;
		lsc_pkg::mag_t en;
		lsc_pkg::snum_t ex;
	} axis_t;

	function automatic lsc_pkg::snum_t ext(lsc_pkg::coord_t v);
		return lsc_pkg::snum_t'(v);
	endfunction

	function automatic axis_t clamp_axis(lsc_pkg::mag_t d, lsc_pkg::snum_t en,
		lsc_pkg::snum_t ex);
		axis_t a;
		lsc_pkg::snum_t dn;
		dn = $signed({1'b0, d});
		if (d == '0) begin
			a.den = lsc_pkg::mag_t'(1);
			a.en = '0;
			a.ex = lsc_pkg::snum_t'(1);
		end else begin
			a.den = d;
			a.en = en[C] ? '0 : lsc_pkg::mag_t'(en);
			a.ex = (ex > dn) ? dn : ex;
		end
		return a;
	endfunction

	function automatic lsc_pkg::coord_t finish(lsc_pkg::div_out_t d);
		lsc_pkg::wide_t fl;
		lsc_pkg::wide_t sum;
		fl = lsc_pkg::wide_t'({1'b0, d.quo});
		if (d.neg) begin
			fl = -fl - lsc_pkg::wide_t'(d.rem_nz);
		end
		sum = lsc_pkg::wide_t'(d.base) + fl;
		if (d.rem_nz && sum[C+1]) begin
			sum = sum + lsc_pkg::wide_t'(1);
		end
		return lsc_pkg::coord_t'(sum);
	endfunction

	lsc_pkg::coord_t win_left_q, win_right_q, win_bottom_q, win_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q <= lsc_pkg::WIN_LEFT_RST;
			win_right_q <= lsc_pkg::WIN_RIGHT_RST;
			win_bottom_q <= lsc_pkg::WIN_BOTTOM_RST;
			win_top_q <= lsc_pkg::WIN_TOP_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				lsc_pkg::REG_LEFT: win_left_q <= cfg_data;
				lsc_pkg::REG_RIGHT: win_right_q <= cfg_data;
				lsc_pkg::REG_BOTTOM: win_bottom_q <= cfg_data;
				lsc_pkg::REG_TOP: win_top_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_valid_q;

	assign adv = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_sdiv [lsc_pkg::DIV_STAGES];
	logic ok_sdiv [lsc_pkg::DIV_STAGES];

	lsc_pkg::snum_t dx_c, dy_c, qxl_c, qxr_c, qyb_c, qyt_c;
	geo_t geo_c;
	lsc_pkg::snum_t enx_c, exx_c, eny_c, exy_c;

	always_comb begin
		dx_c = ext(end_x) - ext(start_x);
		dy_c = ext(end_y) - ext(start_y);
		qxl_c = ext(start_x) - ext(win_left_q);
		qxr_c = ext(win_right_q) - ext(start_x);
		qyb_c = ext(start_y) - ext(win_bottom_q);
		qyt_c = ext(win_top_q) - ext(start_y);
		geo_c.x0 = start_x;
		geo_c.y0 = start_y;
		geo_c.xneg = dx_c[C];
		geo_c.yneg = dy_c[C];
		geo_c.adx = dx_c[C] ? lsc_pkg::mag_t'(-dx_c) : lsc_pkg::mag_t'(dx_c);
		geo_c.ady = dy_c[C] ? lsc_pkg::mag_t'(-dy_c) : lsc_pkg::mag_t'(dy_c);
		geo_c.rej = (dx_c == '0 && (qxl_c[C] || qxr_c[C]))
			|| (dy_c == '0 && (qyb_c[C] || qyt_c[C]));
		enx_c = dx_c[C] ? -qxr_c : -qxl_c;
		exx_c = dx_c[C] ? qxl_c : qxr_c;
		eny_c = dy_c[C] ? -qyt_c : -qyb_c;
		exy_c = dy_c[C] ? qyb_c : qyt_c;
	end

	geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5;
	lsc_pkg::snum_t enx_s1, exx_s1, eny_s1, exy_s1;
	axis_t ax_s2, ay_s2, ax_s3, ay_s3;
	lsc_pkg::prod_t pe_x_s3, pe_y_s3;
	lsc_pkg::sprod_t px_x_s3, px_y_s3;
	lsc_pkg::mag_t en_num_s4, en_den_s4, ex_den_s4, en_den_s5, ex_den_s5;
	lsc_pkg::snum_t ex_num_s4;
	lsc_pkg::prod_t cmp_a_s5, pen_x_s5, pen_y_s5, pex_x_s5, pex_y_s5;
	lsc_pkg::sprod_t cmp_b_s5;
	logic ok_s6;
	lsc_pkg::div_in_t lane_s6 [lsc_pkg::LANES];
	lsc_pkg::div_out_t lane_out [lsc_pkg::LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < lsc_pkg::DIV_STAGES; i++) begin
				vld_sdiv[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_sdiv[0] <= vld_s6;
			for (int i = 1; i < lsc_pkg::DIV_STAGES; i++) begin
				vld_sdiv[i] <= vld_sdiv[i-1];
			end
			out_valid_q <= vld_sdiv[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1 <= geo_c;
			enx_s1 <= enx_c;
			exx_s1 <= exx_c;
			eny_s1 <= eny_c;
			exy_s1 <= exy_c;

			geo_s2 <= geo_s1;
			ax_s2 <= clamp_axis(geo_s1.adx, enx_s1, exx_s1);
			ay_s2 <= clamp_axis(geo_s1.ady, eny_s1, exy_s1);

			geo_s3 <= geo_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;
			pe_x_s3 <= lsc_pkg::prod_t'(ax_s2.en) * lsc_pkg::prod_t'(ay_s2.den);
			pe_y_s3 <= lsc_pkg::prod_t'(ay_s2.en) * lsc_pkg::prod_t'(ax_s2.den);
			px_x_s3 <= lsc_pkg::sprod_t'(ax_s2.ex) * lsc_pkg::sprod_t'({1'b0, ay_s2.den});
			px_y_s3 <= lsc_pkg::sprod_t'(ay_s2.ex) * lsc_pkg::sprod_t'({1'b0, ax_s2.den});

			geo_s4 <= geo_s3;
			if (pe_x_s3 >= pe_y_s3) begin
				en_num_s4 <= ax_s3.en;
				en_den_s4 <= ax_s3.den;
			end else begin
				en_num_s4 <= ay_s3.en;
				en_den_s4 <= ay_s3.den;
			end
			if (px_x_s3 <= px_y_s3) begin
				ex_num_s4 <= ax_s3.ex;
				ex_den_s4 <= ax_s3.den;
			end else begin
				ex_num_s4 <= ay_s3.ex;
				ex_den_s4 <= ay_s3.den;
			end

			geo_s5 <= geo_s4;
			en_den_s5 <= en_den_s4;
			ex_den_s5 <= ex_den_s4;
			cmp_a_s5 <= lsc_pkg::prod_t'(en_num_s4) * lsc_pkg::prod_t'(ex_den_s4);
			cmp_b_s5 <= lsc_pkg::sprod_t'(ex_num_s4) * lsc_pkg::sprod_t'({1'b0, en_den_s4});
			pen_x_s5 <= lsc_pkg::prod_t'(en_num_s4) * lsc_pkg::prod_t'(geo_s4.adx);
			pen_y_s5 <= lsc_pkg::prod_t'(en_num_s4) * lsc_pkg::prod_t'(geo_s4.ady);
			pex_x_s5 <= lsc_pkg::prod_t'(lsc_pkg::mag_t'(ex_num_s4))
				* lsc_pkg::prod_t'(geo_s4.adx);
			pex_y_s5 <= lsc_pkg::prod_t'(lsc_pkg::mag_t'(ex_num_s4))
				* lsc_pkg::prod_t'(geo_s4.ady);

			ok_s6 <= !geo_s5.rej && ($signed({2'b00, cmp_a_s5}) <= cmp_b_s5);
			lane_s6[0] <= '{num: pen_x_s5, den: en_den_s5, base: geo_s5.x0,
				neg: geo_s5.xneg};
			lane_s6[1] <= '{num: pen_y_s5, den: en_den_s5, base: geo_s5.y0,
				neg: geo_s5.yneg};
			lane_s6[2] <= '{num: pex_x_s5, den: ex_den_s5, base: geo_s5.x0,
				neg: geo_s5.xneg};
			lane_s6[3] <= '{num: pex_y_s5, den: ex_den_s5, base: geo_s5.y0,
				neg: geo_s5.yneg};

			ok_sdiv[0] <= ok_s6;
			for (int i = 1; i < lsc_pkg::DIV_STAGES; i++) begin
				ok_sdiv[i] <= ok_sdiv[i-1];
			end
		end
	end

	for (genvar l = 0; l < lsc_pkg::LANES; l++) begin : g_lane
		lsc_divider u_div (
			.clk (clk),
			.adv (adv),
			.din (lane_s6[l]),
			.dout(lane_out[l])
		);
	end

	logic visible_q;
	lsc_pkg::coord_t csx_q, csy_q, cex_q, cey_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			visible_q <= ok_sdiv[LAST];
			csx_q <= ok_sdiv[LAST] ? finish(lane_out[0]) : '0;
			csy_q <= ok_sdiv[LAST] ? finish(lane_out[1]) : '0;
			cex_q <= ok_sdiv[LAST] ? finish(lane_out[2]) : '0;
			cey_q <= ok_sdiv[LAST] ? finish(lane_out[3]) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign visible = visible_q;
	assign clip_start_x = csx_q;
	assign clip_start_y = csy_q;
	assign clip_end_x = cex_q;
	assign clip_end_y = cey_q;

`ifndef SYNTHESIS
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> clip_start_x == '0 && clip_start_y == '0
			&& clip_end_x == '0 && clip_end_y == '0)
		else $error("rejected segment with nonzero coordinates");

	a_hold_front: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_s1) && $stable(vld_s6))
		else $error("pipeline moved while stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sdiv[LAST] && !in_stall |=> out_valid)
		else $error("divider result lost on the way to the output");
`endif

endmodule

>>> tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic vis;
		lsc_pkg::coord_t sx, sy, ex, ey;
	} clip_word_t;

	class clip_scoreboard;
		clip_word_t pending[$];
		int errors;
		longint wl, wr, wb, wt;

		function void set_window(lsc_pkg::cfg_idx_t idx, lsc_pkg::coord_t v);
			case (idx)
				lsc_pkg::REG_LEFT: wl = v;
				lsc_pkg::REG_RIGHT: wr = v;
				lsc_pkg::REG_BOTTOM: wb = v;
				lsc_pkg::REG_TOP: wt = v;
				default: ;
			endcase
		endfunction

		function int cmp_frac(longint an, longint ad, longint bn, longint bd);
			longint l, r;
			l = an * bd;
			r = bn * ad;
			return (l < r) ? -1 : (l > r) ? 1 : 0;
		endfunction

		function lsc_pkg::coord_t point_at(longint x0, longint d, longint un, longint ud);
			longint prod, fl;
			prod = un * d;
			fl = prod / ud;
			if (prod % ud != 0 && prod < 0) fl = fl - 1;
			fl = x0 + fl;
			if (prod % ud != 0 && fl < 0) fl = fl + 1;
			return lsc_pkg::coord_t'(fl);
		endfunction

		function void note_segment(lsc_pkg::coord_t x1, lsc_pkg::coord_t y1,
			lsc_pkg::coord_t x2, lsc_pkg::coord_t y2);
			longint dx, dy, p[4], q[4], en, ed, xn, xd, tn, td;
			bit ok;
			clip_word_t w;
			dx = longint'(x2) - longint'(x1);
			dy = longint'(y2) - longint'(y1);
			p[0] = -dx; q[0] = x1 - wl;
			p[1] = dx;  q[1] = wr - x1;
			p[2] = -dy; q[2] = y1 - wb;
			p[3] = dy;  q[3] = wt - y1;
			en = 0; ed = 1; xn = 1; xd = 1; ok = 1;
			for (int i = 0; i < 4 && ok; i++) begin
				if (p[i] == 0) begin
					if (q[i] < 0) ok = 0;
				end else begin
					td = (p[i] < 0) ? -p[i] : p[i];
					tn = (p[i] < 0) ? -q[i] : q[i];
					if (p[i] < 0) begin
						if (cmp_frac(tn, td, xn, xd) > 0) ok = 0;
						else if (cmp_frac(tn, td, en, ed) > 0) begin
							en = tn; ed = td;
						end
					end else begin
						if (cmp_frac(tn, td, en, ed) < 0) ok = 0;
						else if (cmp_frac(tn, td, xn, xd) < 0) begin
							xn = tn; xd = td;
						end
					end
				end
			end
			w = '{0, 0, 0, 0, 0};
			if (ok) begin
				w.vis = 1;
				w.sx = point_at(x1, dx, en, ed);
				w.sy = point_at(y1, dy, en, ed);
				w.ex = point_at(x1, dx, xn, xd);
				w.ey = point_at(y1, dy, xn, xd);
			end
			pending.push_back(w);
		endfunction

		function void check_result(clip_word_t a);
			clip_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result vis=%0b", $time, a.vis);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (e.vis !== a.vis || e.sx !== a.sx || e.sy !== a.sy ||
					e.ex !== a.ex || e.ey !== a.ey) begin
				$display({"%0t: mismatch expected %0b %0d %0d %0d %0d",
					" actual %0b %0d %0d %0d %0d"},
					$time, e.vis, e.sx, e.sy, e.ex, e.ey,
					a.vis, a.sx, a.sy, a.ex, a.ey);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0, visible;
	lsc_pkg::coord_t start_x = 0, start_y = 0, end_x = 0, end_y = 0;
	lsc_pkg::coord_t clip_start_x, clip_start_y, clip_end_x, clip_end_y;
	logic cfg_write = 0;
	lsc_pkg::cfg_idx_t cfg_index = lsc_pkg::REG_LEFT;
	lsc_pkg::coord_t cfg_data = 0;
	int idle_pct = 37;
	longint cycles = 0;
	clip_scoreboard sb = new();

	line_segment_clipper dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{visible, clip_start_x, clip_start_y, clip_end_x,
				clip_end_y});
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	task automatic write_reg(lsc_pkg::cfg_idx_t idx, lsc_pkg::coord_t v);
		cfg_write <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		sb.set_window(idx, v);
	endtask

	task automatic set_window(lsc_pkg::coord_t l, lsc_pkg::coord_t r,
		lsc_pkg::coord_t b, lsc_pkg::coord_t t);
		write_reg(lsc_pkg::REG_LEFT, l);
		write_reg(lsc_pkg::REG_RIGHT, r);
		write_reg(lsc_pkg::REG_BOTTOM, b);
		write_reg(lsc_pkg::REG_TOP, t);
		cfg_write <= 0;
	endtask

	task automatic send_segment(lsc_pkg::coord_t x1, lsc_pkg::coord_t y1,
		lsc_pkg::coord_t x2, lsc_pkg::coord_t y2);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		start_x <= x1; start_y <= y1; end_x <= x2; end_y <= y2;
		do @(posedge clk); while (in_stall);
		sb.note_segment(x1, y1, x2, y2);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic lsc_pkg::coord_t rand_coord(int span);
		if ($urandom_range(9) == 0) return lsc_pkg::coord_t'($urandom);
		return lsc_pkg::coord_t'($signed($urandom_range(2 * span)) - span);
	endfunction

	initial begin
		lsc_pkg::coord_t ext[4];
		sb.wl = -100; sb.wr = 100; sb.wb = -100; sb.wt = 100;
		ext = '{16'sh8000, 16'sh7fff, 0, -1};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_segment(-200, 0, 200, 0);
		send_segment(-200, 0, -150, 50);
		send_segment(-200, 150, 200, 150);
		send_segment(0, 0, 0, 0);
		send_segment(300, 300, 300, 300);
		send_segment(-100, -100, -100, -100);
		send_segment(-200, 100, 0, 300);
		send_segment(-200, 200, 200, -200);
		send_segment(7, -300, 13, 301);
		send_segment(ext[0], ext[0], ext[1], ext[1]);
		send_segment(ext[1], ext[0], ext[0], ext[1]);
		send_segment(ext[2], ext[3], ext[0], ext[1]);
		drain();
		set_window(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		send_segment(ext[0], ext[1], ext[1], ext[0]);
		send_segment(-5, 3, 17, -9);
		drain();
		set_window(50, -50, -10, 10);
		send_segment(0, 0, 1, 1);
		send_segment(-100, 0, 100, 0);
		drain();
		set_window(0, 0, 0, 0);
		send_segment(-3, -3, 3, 3);
		send_segment(-3, -2, 3, 3);
		drain();
		for (int ph = 0; ph < 7; ph++) begin
			lsc_pkg::coord_t l, b;
			l = rand_coord(300); b = rand_coord(300);
			set_window(l, lsc_pkg::coord_t'(l + $urandom_range(400)), b,
				lsc_pkg::coord_t'(b + $urandom_range(400)));
			idle_pct = (ph == 3) ? 0 : 37;
			for (int i = 0; i < 100; i++) begin
				send_segment(rand_coord(600), rand_coord(600),
					rand_coord(600), rand_coord(600));
				if (i == 50) drain();
			end
			drain();
		end
		idle_pct = 0;
		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
